// ----- design/nnsa_pkg.sv -----
// ----------------------------------------------------------------------------
// nnsa_pkg: shared types and constants of the nearest-neighbor address unit
// Holds the channel payload structs, the pipeline data structs and the
// dimension clamp that the front end, the divider cells and the top share.
// ----------------------------------------------------------------------------
package nnsa_pkg;

  localparam int unsigned MAX_SIDE   = 4096;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned OFFSET_W   = 24;
  // Quotient bits per divider; one divider cell per bit.
  localparam int unsigned QUOT_W     = COORD_W;
  // Dividend is a coordinate times a clamped dimension, always below 2**24.
  localparam int unsigned DIVIDEND_W = 24;

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_col;
    logic [COORD_W-1:0] dest_row;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  source_col;
    logic [COORD_W-1:0]  source_row;
    logic [OFFSET_W-1:0] source_offset;
    logic                in_range;
  } out_item_t;

  // Frame dimensions, already clamped to MAX_SIDE.
  typedef struct packed {
    logic [DIM_W-1:0] source_width;
    logic [DIM_W-1:0] source_height;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
  } dims_t;

  // One long-division lane: partial remainder, aligned divisor, quotient so far.
  typedef struct packed {
    logic [DIVIDEND_W-1:0] rem;
    logic [DIVIDEND_W-1:0] dsh;
    logic [QUOT_W-1:0]     quot;
  } div_lane_t;

  typedef struct packed {
    div_lane_t col;
    div_lane_t row;
    logic      in_range;
  } cell_data_t;

  function automatic logic [DIM_W-1:0] clamp_side(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_SIDE);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ----- design/nearest_neighbor_scale_address_top.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_top: nearest-neighbor source address unit
// Maps a destination pixel coordinate to its nearest source pixel and the
// linear offset of that pixel in the source frame.
// ----------------------------------------------------------------------------
// Usage:
// A destination coordinate is presented on in_valid/in_data and one transfer
// takes place at each clock edge with in_valid high and in_stall low. Every
// input transfer produces exactly one result transfer on out_valid/out_data,
// in order. The four frame dimensions are written on the cfg_ port (index 0
// source width, 1 source height, 2 target width, 3 target height); values
// above 4096 are treated as 4096. Write them only while no item is in flight.
// The pipeline is 14 register stages deep: one stage for the range check and
// the coordinate-times-dimension multiply, twelve stages in the chain of
// divider cells (one quotient bit per cell), and one for the row-times-width
// offset multiply-add into the output register. Throughput is one item per
// clock while the receiver does not stall. When the receiver stalls with a
// result waiting, the whole pipeline holds and in_stall is raised; it drops
// as soon as the result is taken. Reset empties the pipeline and sets all
// four dimensions to 1.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nnsa_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nnsa_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [nnsa_pkg::DIM_W-1:0] cfg_wdata
);
  import nnsa_pkg::*;

  dims_t      dims_r;
  logic       advance;
  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  out_data_nxt;
  logic       stage_valid [QUOT_W+1];
  cell_data_t stage_data  [QUOT_W+1];
  logic [OFFSET_W-1:0] offset_sum;

  // The pipeline moves as a whole whenever the output register is free or
  // its result is being taken this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // Configuration registers, stored already clamped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.source_width  <= DIM_W'(1);
      dims_r.source_height <= DIM_W'(1);
      dims_r.dst_width     <= DIM_W'(1);
      dims_r.dst_height    <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SOURCE_WIDTH:  dims_r.source_width  <= clamp_side(cfg_wdata);
        REG_SOURCE_HEIGHT: dims_r.source_height <= clamp_side(cfg_wdata);
        REG_TARGET_WIDTH:  dims_r.dst_width     <= clamp_side(cfg_wdata);
        REG_TARGET_HEIGHT: dims_r.dst_height    <= clamp_side(cfg_wdata);
        default: ;
      endcase
    end
  end

  nnsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .dims      (dims_r),
    .out_valid (stage_valid[0]),
    .out_data  (stage_data[0])
  );

  // Chain of divider cells, most significant quotient bit first.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
    nnsa_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .in_valid  (stage_valid[k]),
      .in_data   (stage_data[k]),
      .out_valid (stage_valid[k+1]),
      .out_data  (stage_data[k+1])
    );
  end

  // Quotients are zero for out-of-frame items, so the offset is zero too.
  // In frame, with both source sides nonzero, the offset is below source width
  // times source height, which is at most 2**24.
  always_comb begin
    offset_sum = OFFSET_W'(stage_data[QUOT_W].row.quot) * OFFSET_W'(dims_r.source_width)
               + OFFSET_W'(stage_data[QUOT_W].col.quot);
    out_data_nxt.source_col    = stage_data[QUOT_W].col.quot;
    out_data_nxt.source_row    = stage_data[QUOT_W].row.quot;
    out_data_nxt.source_offset = offset_sum;
    out_data_nxt.in_range      = stage_data[QUOT_W].in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stage_valid[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.in_range |->
      (out_data_r.source_col == '0) && (out_data_r.source_row == '0) &&
      (out_data_r.source_offset == '0))
    else $error("nonzero result for out-of-frame coordinate");
  a_col_in_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.in_range && (dims_r.source_width != '0) |->
      ({1'b0, out_data_r.source_col} < dims_r.source_width))
    else $error("source column outside source frame");
  a_row_in_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.in_range && (dims_r.source_height != '0) |->
      ({1'b0, out_data_r.source_row} < dims_r.source_height))
    else $error("source row outside source frame");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(stage_valid[QUOT_W]) && $stable(stage_valid[0]))
    else $error("pipeline moved while the result was stalled");

endmodule

// ----- design/nnsa_front.sv -----
// ----------------------------------------------------------------------------
// nnsa_front: range check and product stage
// Checks the destination coordinate against the target frame and forms the
// two dividends coordinate*source_dimension for the divider chain.
// ----------------------------------------------------------------------------
module nnsa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                in_valid,
  input  nnsa_pkg::in_item_t  in_data,
  input  nnsa_pkg::dims_t     dims,
  output logic                out_valid,
  output nnsa_pkg::cell_data_t out_data
);
  import nnsa_pkg::*;

  logic                  valid_r;
  cell_data_t            data_r;
  cell_data_t            data_nxt;
  logic                  hit;
  logic [DIVIDEND_W-1:0] prod_col;
  logic [DIVIDEND_W-1:0] prod_row;
  logic [DIM_W-1:0]      div_col;
  logic [DIM_W-1:0]      div_row;

  always_comb begin
    hit = ({1'b0, in_data.dest_col} < dims.dst_width) &&
          ({1'b0, in_data.dest_row} < dims.dst_height);
    // A 12-bit coordinate times a side of at most 4096 stays below 2**24.
    prod_col = DIVIDEND_W'(in_data.dest_col) * DIVIDEND_W'(dims.source_width);
    prod_row = DIVIDEND_W'(in_data.dest_row) * DIVIDEND_W'(dims.source_height);
    // Outside the frame the dividend is zero and the divisor one, so the
    // chain yields a zero quotient and no division by zero occurs.
    div_col = hit ? dims.dst_width  : DIM_W'(1);
    div_row = hit ? dims.dst_height : DIM_W'(1);
    data_nxt.in_range  = hit;
    data_nxt.col.rem   = hit ? prod_col : '0;
    data_nxt.row.rem   = hit ? prod_row : '0;
    data_nxt.col.dsh   = DIVIDEND_W'(div_col) << (QUOT_W-1);
    data_nxt.row.dsh   = DIVIDEND_W'(div_row) << (QUOT_W-1);
    data_nxt.col.quot  = '0;
    data_nxt.row.quot  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- design/nnsa_div_cell.sv -----
// ----------------------------------------------------------------------------
// nnsa_div_cell: one restoring-division step for both axes
// Compares the partial remainder with the aligned divisor, subtracts when it
// fits, shifts in one quotient bit and halves the divisor for the next cell.
// ----------------------------------------------------------------------------
module nnsa_div_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 in_valid,
  input  nnsa_pkg::cell_data_t in_data,
  output logic                 out_valid,
  output nnsa_pkg::cell_data_t out_data
);
  import nnsa_pkg::*;

  logic       valid_r;
  cell_data_t data_r;
  cell_data_t data_nxt;

  function automatic div_lane_t step(input div_lane_t l);
    div_lane_t r;
    logic      fits;
    fits   = (l.rem >= l.dsh);
    r.rem  = fits ? (l.rem - l.dsh) : l.rem;
    r.quot = {l.quot[QUOT_W-2:0], fits};
    r.dsh  = l.dsh >> 1;
    return r;
  endfunction

  always_comb begin
    data_nxt.col      = step(in_data.col);
    data_nxt.row      = step(in_data.row);
    data_nxt.in_range = in_data.in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  // The remainder left by this step is below the divisor at the bit just
  // decided, otherwise a quotient bit was lost upstream. Halving may drop the
  // low divisor bit, so the bound is twice the halved divisor, inclusive.
  a_col_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ({1'b0, data_r.col.rem} <= {data_r.col.dsh, 1'b0}))
    else $error("column remainder exceeds divisor");
  a_row_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ({1'b0, data_r.row.rem} <= {data_r.row.dsh, 1'b0}))
    else $error("row remainder exceeds divisor");
  a_out_zero_quot: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !data_r.in_range |-> (data_r.col.quot == '0) && (data_r.row.quot == '0))
    else $error("quotient set for out-of-frame coordinate");

endmodule

// ----- verif/nnsa_checker.sv -----
// ----------------------------------------------------------------------------
// nnsa_checker: result checker for the nearest-neighbor address unit
// Follows configuration writes, computes the source coordinate and offset
// for every accepted destination coordinate, and compares each accepted
// result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module nnsa_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  nnsa_pkg::in_item_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  nnsa_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [nnsa_pkg::DIM_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);
  import nnsa_pkg::*;

  logic [DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  out_item_t        source_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Registers above the largest frame side act as that side.
  function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : v;
  endfunction

  function automatic out_item_t map_to_source(input in_item_t px);
    out_item_t        res;
    logic [DIM_W-1:0] sw, sh, tw, th;
    logic [31:0]      sc, sr, off;
    sw  = limit_dim(src_w_q);
    sh  = limit_dim(src_h_q);
    tw  = limit_dim(dst_w_q);
    th  = limit_dim(dst_h_q);
    res = '0;
    // A zero target side leaves nothing inside, so no division happens.
    if (DIM_W'(px.dest_col) < tw && DIM_W'(px.dest_row) < th) begin
      sc  = (32'(px.dest_col) * 32'(sw)) / 32'(tw);
      sr  = (32'(px.dest_row) * 32'(sh)) / 32'(th);
      off = sr * 32'(sw) + sc;
      res.source_col    = sc[COORD_W-1:0];
      res.source_row    = sr[COORD_W-1:0];
      res.source_offset = off[OFFSET_W-1:0];
      res.in_range      = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    bit        bad;
    if (!rst_n) begin
      src_w_q = DIM_W'(1);
      src_h_q = DIM_W'(1);
      dst_w_q = DIM_W'(1);
      dst_h_q = DIM_W'(1);
      source_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_SOURCE_WIDTH:  src_w_q = cfg_wdata;
          REG_SOURCE_HEIGHT: src_h_q = cfg_wdata;
          REG_TARGET_WIDTH:  dst_w_q = cfg_wdata;
          REG_TARGET_HEIGHT: dst_h_q = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        bad = 1'b0;
        if (source_q.size() == 0) begin
          $error("result transfer with no prediction outstanding");
          bad = 1'b1;
        end else begin
          want = source_q.pop_front();
          if (out_data.source_col !== want.source_col) begin
            $error("source_col: expected %0d, actual %0d", want.source_col,
                   out_data.source_col);
            bad = 1'b1;
          end
          if (out_data.source_row !== want.source_row) begin
            $error("source_row: expected %0d, actual %0d", want.source_row,
                   out_data.source_row);
            bad = 1'b1;
          end
          if (out_data.source_offset !== want.source_offset) begin
            $error("source_offset: expected %0d, actual %0d", want.source_offset,
                   out_data.source_offset);
            bad = 1'b1;
          end
          if (out_data.in_range !== want.in_range) begin
            $error("in_range: expected %0d, actual %0d", want.in_range,
                   out_data.in_range);
            bad = 1'b1;
          end
        end
        if (bad) fail_count <= fail_count + 1;
      end
      if (in_valid && !in_stall) source_q.push_back(map_to_source(in_data));
    end
    pending <= source_q.size();
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the nearest-neighbor address unit
// Writes a series of frame geometries, sends a short directed set of
// destination coordinates and then random ones under random source gaps and
// receiver stalls, and leaves all prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb;
  import nnsa_pkg::*;

  localparam int STALL_PCT    = 25;
  localparam int IDLE_LIMIT   = 2000;
  // Longer than the pipeline is deep.
  localparam int DRAIN_CYCLES = 30;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = REG_SOURCE_WIDTH;
  logic [DIM_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  // While set, neither side inserts gaps, so the pipeline runs at full rate.
  bit no_gaps     = 1'b0;

  always #5 clk = ~clk;

  nearest_neighbor_scale_address_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nnsa_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The receiver stalls in about a quarter of the cycles while no_gaps is clear,
  // drawn fresh at every edge so that stalls land on every stage of the pipeline.
  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(0, 99) < STALL_PCT);
  end

  // Watchdog: any transfer on either channel restarts the count, so only a
  // hung block can run it out.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one coordinate, after a random number of idle cycles, and holds
  // it until the transfer takes place. Valid stays high into the next item
  // when no gap is drawn.
  task automatic push_coord(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    while (!no_gaps && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data.dest_col <= col;
    in_data.dest_row <= row;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_dim(input reg_index_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[DIM_W-1:0];
    @(posedge clk);
  endtask

  // Registers change only with the pipeline empty. The task waits on the clock
  // first, so that the checker has counted the last input transfer before the
  // outstanding count is read. Every input yields a result, so an empty
  // prediction queue means an empty pipeline.
  task automatic apply_dims(input int sw, input int sh, input int tw, input int th);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_dim(REG_SOURCE_WIDTH, sw);
    write_dim(REG_SOURCE_HEIGHT, sh);
    write_dim(REG_TARGET_WIDTH, tw);
    write_dim(REG_TARGET_HEIGHT, th);
    cfg_we <= 1'b0;
  endtask

  // Frame sides: mostly legal, with some zero, some tiny and some above the
  // largest side so that saturation is exercised.
  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return $urandom_range(MAX_SIDE + 1, 8191);
    if (r < 40) return $urandom_range(1, 16);
    return $urandom_range(1, MAX_SIDE);
  endfunction

  // Most coordinates fall inside the target frame, some sit right on its
  // border and the rest cover the whole field range.
  task automatic run_random(input int count, input int tw, input int th);
    int lim_w, lim_h, r;
    logic [COORD_W-1:0] col, row;
    lim_w = (tw > MAX_SIDE) ? MAX_SIDE : tw;
    lim_h = (th > MAX_SIDE) ? MAX_SIDE : th;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70 && lim_w > 0 && lim_h > 0) begin
        col = COORD_W'($urandom_range(0, lim_w - 1));
        row = COORD_W'($urandom_range(0, lim_h - 1));
      end else if (r < 85) begin
        col = COORD_W'(lim_w - 1 + $urandom_range(0, 1));
        row = COORD_W'(lim_h - 1 + $urandom_range(0, 1));
      end else begin
        col = COORD_W'($urandom_range(0, 4095));
        row = COORD_W'($urandom_range(0, 4095));
      end
      push_coord(col, row);
    end
  endtask

  initial begin
    int sw, sh, tw, th;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry is one pixel on every side: only the origin is inside.
    push_coord(12'd0, 12'd0);
    push_coord(12'd1, 12'd0);
    push_coord(12'd0, 12'd1);

    // Oversized registers saturate to the largest side, giving the identity
    // mapping over the full coordinate range.
    apply_dims(8191, 5000, 4097, MAX_SIDE);
    push_coord(12'd0, 12'd0);
    push_coord(12'hFFF, 12'hFFF);
    push_coord(12'hFFF, 12'd0);
    push_coord(12'd0, 12'hFFF);
    push_coord(12'hAAA, 12'h555);
    push_coord(12'h555, 12'hAAA);

    // A zero source side collapses the source coordinate to zero.
    apply_dims(0, 0, 640, 480);
    push_coord(12'd639, 12'd479);
    push_coord(12'd640, 12'd0);
    push_coord(12'd0, 12'd480);
    push_coord(12'd100, 12'd100);

    // A zero target side leaves every coordinate outside the frame.
    apply_dims(640, 480, 0, 0);
    push_coord(12'd0, 12'd0);
    push_coord(12'd5, 12'd5);

    // Strong downscale with a remainder in the division.
    apply_dims(MAX_SIDE, MAX_SIDE, 3, 3);
    push_coord(12'd2, 12'd2);
    push_coord(12'd3, 12'd0);

    // Upscale at full rate: a long stretch with no gaps on either side.
    no_gaps <= 1'b1;
    apply_dims(320, 240, 1280, 720);
    run_random(150, 1280, 720);
    no_gaps <= 1'b0;

    apply_dims(1280, 720, 320, 240);
    run_random(110, 320, 240);
    apply_dims(1, 1, MAX_SIDE, MAX_SIDE);
    run_random(110, MAX_SIDE, MAX_SIDE);
    apply_dims(MAX_SIDE, MAX_SIDE, 1, 1);
    run_random(60, 1, 1);

    for (int p = 0; p < 6; p++) begin
      sw = pick_dim();
      sh = pick_dim();
      tw = pick_dim();
      th = pick_dim();
      apply_dims(sw, sh, tw, th);
      run_random(110, tw, th);
    end

    // Let every outstanding result arrive, then wait longer than the pipeline
    // is deep, so that any stray extra transfer is caught.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
